/* rtl/mme_pkg.sv */
`default_nettype none

package mme_pkg;

    // Fixed field widths of the words on the ports
    localparam int unsigned OP_W     = 2;
    localparam int unsigned IDX_F_W  = 4;
    localparam int unsigned ELEM_W   = 16;
    localparam int unsigned SIZE_W   = 5;
    localparam int unsigned PROD_W   = 2 * ELEM_W;
    localparam int unsigned ACC_W    = 36;

    // Matrix dimension after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_seq_state;

    // Tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic               valid;
        logic               k_first;
        logic               k_last;
        logic               j_last;
        logic [IDX_F_W-1:0] col;
    } t_mac_tag;

endpackage

`default_nettype wire

/* rtl/mme_in_if.sv */
`default_nettype none

interface mme_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] element;

    modport source (output valid, op, row, col, element, input ready);
    modport sink   (input valid, op, row, col, element, output ready);
endinterface

`default_nettype wire

/* rtl/mme_out_if.sv */
`default_nettype none

interface mme_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic signed [35:0] product_value;
    logic               last;

    modport source (output valid, out_row, out_col, product_value, last, input ready);
    modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

`default_nettype wire

/* rtl/matrix_multiply_engine.sv */
`default_nettype none
// Load word (op 0/1): written in the accept cycle, next word taken in the cycle after.
// Compute word: n*n multiply-accumulates on one multiplier, n = effective size, one per
//   cycle while the output is not held; the next word is taken once the MAC pipe is empty.
//   The row rate is set by the single MAC and store read port.
// Synchronous active-low reset clears control and sets the size register to 16; the A and B
// stores are not cleared and hold garbage until written.
module matrix_multiply_engine #(
    parameter int unsigned MAX_N = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [mme_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    mme_in_if.sink                           i_in,
    mme_out_if.source                        o_out
);
    import mme_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_N);
    localparam int unsigned DEPTH  = MAX_N * MAX_N;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [SIZE_W-1:0]   r_size;
    logic                wr_a, wr_b, rd_en, advance, mac_busy;
    logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
    logic [ELEM_W-1:0]   a_data, b_data;
    t_mac_tag            tag;
    logic [IDX_F_W-1:0]  row;
    logic [IDX_W-1:0]    seq_nm1;

    // Dimension register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    mme_seq #(.MAX_N(MAX_N)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (r_size),
        .i_in        (i_in),
        .i_advance   (advance),
        .i_mac_busy  (mac_busy),
        .o_wr_a      (wr_a),
        .o_wr_b      (wr_b),
        .o_wr_addr   (wr_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_tag       (tag),
        .o_row       (row),
        .o_nm1       (seq_nm1)
    );

    // A store, row-major with stride MAX_N
    mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.element),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (a_data)
    );

    // B store, same layout
    mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.element),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (b_data)
    );

    mme_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (tag),
        .i_a       (a_data),
        .i_b       (b_data),
        .i_row     (row),
        .o_out     (o_out),
        .o_advance (advance),
        .o_busy    (mac_busy)
    );

    // New words are only taken with the MAC pipe empty
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !mac_busy)
        else $error("input word taken while MAC pipe busy");

    // Row end marker sits on the last column in use
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.out_col == IDX_F_W'(seq_nm1)))
        else $error("last flag on wrong column");

    // A result only appears out of a busy pipe
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(mac_busy))
        else $error("result word without work in flight");

endmodule

`default_nettype wire

/* rtl/mme_ram.sv */
`default_nettype none

module mme_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/mme_seq.sv */
`default_nettype none

module mme_seq #(
    parameter int unsigned MAX_N = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [mme_pkg::SIZE_W-1:0]      i_size,
    mme_in_if.sink                               i_in,
    input  wire logic                            i_advance,
    input  wire logic                            i_mac_busy,
    output logic                                 o_wr_a,
    output logic                                 o_wr_b,
    output logic [$clog2(MAX_N*MAX_N)-1:0]       o_wr_addr,
    output logic                                 o_rd_en,
    output logic [$clog2(MAX_N*MAX_N)-1:0]       o_rd_addr_a,
    output logic [$clog2(MAX_N*MAX_N)-1:0]       o_rd_addr_b,
    output mme_pkg::t_mac_tag                    o_tag,
    output logic [mme_pkg::IDX_F_W-1:0]          o_row,
    output logic [$clog2(MAX_N)-1:0]             o_nm1
);
    import mme_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_N);
    localparam int unsigned N_W    = $clog2(MAX_N + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_N * MAX_N);

    t_seq_state         r_state, n_state;
    logic [IDX_W-1:0]   r_row, r_k, r_j, r_nm1;
    logic [N_W-1:0]     n_eff;
    logic               accept, load_ok, comp_ok, start;
    logic               k_last, j_last;
    logic [IDX_W-1:0]   ld_row, ld_col;

    // Effective size: zero acts as one, clamp at MAX_N
    always_comb begin
        if (i_size == '0) begin
            n_eff = N_W'(1);
        end else if (32'(i_size) > 32'(MAX_N)) begin
            n_eff = N_W'(MAX_N);
        end else begin
            n_eff = N_W'(i_size);
        end
    end

    assign accept  = i_in.valid && i_in.ready;
    assign load_ok = (32'(i_in.row) < 32'(MAX_N)) && (32'(i_in.col) < 32'(MAX_N));
    assign comp_ok = 32'(i_in.row) < 32'(n_eff);
    assign start   = accept && (i_in.op == OP_COMPUTE) && comp_ok;
    assign ld_row  = IDX_W'(i_in.row);
    assign ld_col  = IDX_W'(i_in.col);
    assign k_last  = (r_k == r_nm1);
    assign j_last  = (r_j == r_nm1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_advance && k_last && j_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_mac_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: handshake, store writes, read issue and MAC tag
    always_comb begin
        i_in.ready    = (r_state == ST_IDLE);
        o_wr_a        = accept && (i_in.op == OP_LOAD_A) && load_ok;
        o_wr_b        = accept && (i_in.op == OP_LOAD_B) && load_ok;
        o_wr_addr     = ADDR_W'(32'(ld_row) * MAX_N + 32'(ld_col));
        o_rd_en       = i_advance;
        o_rd_addr_a   = ADDR_W'(32'(r_row) * MAX_N + 32'(r_k));
        o_rd_addr_b   = ADDR_W'(32'(r_k) * MAX_N + 32'(r_j));
        o_tag.valid   = (r_state == ST_RUN) && i_advance;
        o_tag.k_first = (r_k == '0);
        o_tag.k_last  = k_last;
        o_tag.j_last  = j_last;
        o_tag.col     = IDX_F_W'(r_j);
        o_row         = IDX_F_W'(r_row);
        o_nm1         = r_nm1;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Loop counters: k inner (dot product), j outer (column)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_j <= '0;
        end else if (start) begin
            r_k <= '0;
            r_j <= '0;
        end else if (r_state == ST_RUN && i_advance) begin
            if (k_last) begin
                r_k <= '0;
                r_j <= r_j + IDX_W'(1);
            end else begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    // Row and size of the row in work
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row <= ld_row;
            r_nm1 <= IDX_W'(n_eff - N_W'(1));
        end
    end

endmodule

`default_nettype wire

/* rtl/mme_mac.sv */
`default_nettype none

module mme_mac (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mme_pkg::t_mac_tag              i_tag,
    input  wire logic [mme_pkg::ELEM_W-1:0]     i_a,
    input  wire logic [mme_pkg::ELEM_W-1:0]     i_b,
    input  wire logic [mme_pkg::IDX_F_W-1:0]    i_row,
    mme_out_if.source                           o_out,
    output logic                                o_advance,
    output logic                                o_busy
);
    import mme_pkg::*;

    t_mac_tag                  r_tag1, r_tag2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   sum;
    logic                      r_out_valid;
    logic [IDX_F_W-1:0]        r_out_row, r_out_col;
    logic signed [ACC_W-1:0]   r_out_val;
    logic                      r_out_last;

    // Whole pipe moves unless a finished word is held at the output
    assign o_advance = !r_out_valid || o_out.ready;
    assign o_busy    = r_tag1.valid || r_tag2.valid;

    // Accumulate: first term of a dot product restarts the sum
    always_comb begin
        if (r_tag2.k_first) begin
            sum = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end else begin
            sum = r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Tag pipeline: tag1 lines up with store read data, tag2 with product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else if (o_advance) begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    // Shared multiplier and accumulator
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_prod <= PROD_W'($signed(i_a)) * PROD_W'($signed(i_b));
            if (r_tag2.valid) begin
                r_acc <= sum;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && r_tag2.valid && r_tag2.k_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && r_tag2.valid && r_tag2.k_last) begin
            r_out_row  <= i_row;
            r_out_col  <= r_tag2.col;
            r_out_val  <= sum;
            r_out_last <= r_tag2.j_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.product_value = r_out_val;
    assign o_out.last          = r_out_last;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    localparam int MAX_N         = 16;
    localparam int SETTLE_CYCLES = 300;      // above the row time at n = 16
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_MAX    = 10;

    // op 3 has no meaning in the block and must be dropped
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_F_W-1:0]      row;
        logic [IDX_F_W-1:0]      col;
        logic signed [ACC_W-1:0] value;
        logic                    last;
    } t_product;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [SIZE_W-1:0]   i_cfg_wr_data;

    mme_in_if  in_if ();
    mme_out_if out_if ();

    matrix_multiply_engine #(.MAX_N(MAX_N)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // Shadow copy of the block: both stores (row-major, stride MAX_N) and the size
    logic signed [ELEM_W-1:0] a_shadow [0:MAX_N*MAX_N-1];
    logic signed [ELEM_W-1:0] b_shadow [0:MAX_N*MAX_N-1];
    logic [SIZE_W-1:0]        size_shadow;

    // A entries written so far; B is filled completely up front
    bit a_written [0:MAX_N*MAX_N-1];

    t_product expected_products [$];
    int       mismatch_count;
    int       cycle_count;

    // Traffic shaping knobs
    bit sender_gaps;
    bit rx_stalls;
    bit hold_req;
    int burst_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Size actually used: 0 acts as 1, anything above MAX_N acts as MAX_N
    function automatic int eff_size(logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return 1;
        end
        if (s > MAX_N) begin
            return MAX_N;
        end
        return int'(s);
    endfunction

    // True when the first n entries of A row r have all been written
    function automatic bit row_loaded(int r, int n);
        int k;
        for (k = 0; k < n; k++) begin
            if (!a_written[r * MAX_N + k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Random row below n whose A entries are written; row 0 always is
    function automatic logic [IDX_F_W-1:0] pick_row(int n);
        int r;
        r = $urandom_range(0, n - 1);
        if (!row_loaded(r, n)) begin
            r = 0;
        end
        return IDX_F_W'(r);
    endfunction

    // Queue one row of C = A x B, exact Q20.16 sums
    function automatic void predict_row_products(logic [IDX_F_W-1:0] r);
        int       n;
        int       j;
        int       k;
        longint   acc;
        t_product p;
        n = eff_size(size_shadow);
        if (r >= n) begin
            return;
        end
        for (j = 0; j < n; j++) begin
            acc = 0;
            for (k = 0; k < n; k++) begin
                acc += longint'(a_shadow[r * MAX_N + k]) * longint'(b_shadow[k * MAX_N + j]);
            end
            p.row   = r;
            p.col   = j[IDX_F_W-1:0];
            p.value = acc[ACC_W-1:0];
            p.last  = (j == n - 1);
            expected_products.push_back(p);
        end
    endfunction

    // Element mix weighted toward the Q8.8 extremes
    function automatic logic [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 9))
            0: begin
                return 16'h8000;
            end
            1: begin
                return 16'h7FFF;
            end
            2: begin
                return 16'h0000;
            end
            3: begin
                return 16'hFFFF;
            end
            default: begin
                return ELEM_W'($urandom);
            end
        endcase
    endfunction

    // Offer one word, in bursts with random gaps when enabled, and update the shadow on accept
    task automatic send_word(logic [OP_W-1:0] op, logic [IDX_F_W-1:0] row,
                             logic [IDX_F_W-1:0] col, logic [ELEM_W-1:0] elem);
        if (sender_gaps && burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_if.valid   <= 1'b1;
        in_if.op      <= op;
        in_if.row     <= row;
        in_if.col     <= col;
        in_if.element <= elem;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        case (op)
            OP_LOAD_A: begin
                a_shadow[{row, col}]  = elem;
                a_written[{row, col}] = 1'b1;
            end
            OP_LOAD_B: begin
                b_shadow[{row, col}] = elem;
            end
            OP_COMPUTE: begin
                predict_row_products(row);
            end
            default: begin
            end
        endcase
    endtask

    // Drop valid, let every product word come out, then cover rows with no output
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Size register write, only with the block idle
    task automatic set_matrix_size(logic [SIZE_W-1:0] v);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        size_shadow = v;
    endtask

    task automatic send_compute(logic [IDX_F_W-1:0] row);
        send_word(OP_COMPUTE, row, IDX_F_W'($urandom), ELEM_W'($urandom));
    endtask

    // Write all of B and rows 0, 1 and 15 of A; computes only name fully written A rows.
    // A row 0 x B col 0 gives the largest sum, A row 1 x B col 1 the most negative.
    task automatic test_fill_stores();
        int          r;
        int          c;
        logic [15:0] v;
        for (r = 0; r < MAX_N; r++) begin
            if (r == 0 || r == 1 || r == MAX_N - 1) begin
                for (c = 0; c < MAX_N; c++) begin
                    if (r == 0) begin
                        v = 16'h8000;
                    end else if (r == 1) begin
                        v = 16'h7FFF;
                    end else begin
                        v = rand_element();
                    end
                    send_word(OP_LOAD_A, IDX_F_W'(r), IDX_F_W'(c), v);
                end
            end
        end
        for (r = 0; r < MAX_N; r++) begin
            for (c = 0; c < MAX_N; c++) begin
                v = (c < 2) ? 16'h8000 : rand_element();
                send_word(OP_LOAD_B, IDX_F_W'(r), IDX_F_W'(c), v);
            end
        end
    endtask

    // Size left at its reset value: full 16x16 rows, plus an unused op
    task automatic test_reset_size();
        send_compute(4'd0);
        send_compute(4'd1);
        send_word(OP_UNUSED, 4'd15, 4'd15, 16'hFFFF);
        send_compute(4'd15);
    endtask

    // Size register extremes, clamping, and rows past the size
    task automatic test_size_extremes();
        set_matrix_size(5'd1);
        send_compute(4'd0);
        send_compute(4'd1);
        send_compute(4'd15);
        set_matrix_size(5'd0);
        send_compute(4'd0);
        send_compute(4'd9);
        set_matrix_size(5'd31);
        send_compute(4'd15);
        send_compute(4'd1);
        set_matrix_size(5'd17);
        send_compute(4'd0);
        set_matrix_size(5'd2);
        send_compute(4'd1);
        send_compute(4'd2);
        send_word(OP_LOAD_A, 4'd0, 4'd1, 16'h7FFF);
        send_compute(4'd0);
    endtask

    // Receiver holds off for a long stretch while computes keep coming
    task automatic test_output_holdoff();
        int i;
        set_matrix_size(5'd4);
        sender_gaps = 1'b0;
        hold_req    = 1'b1;
        for (i = 0; i < 8; i++) begin
            send_compute(pick_row(4));
        end
        sender_gaps = 1'b1;
    endtask

    // Random phases: mostly loads and valid computes, some noise words
    task automatic test_random_traffic();
        int                phase;
        int                i;
        int                n;
        int                pick;
        logic [SIZE_W-1:0] sz;
        logic [OP_W-1:0]   op;
        logic [3:0]        r;
        logic [3:0]        c;
        for (phase = 0; phase < 4; phase++) begin
            if (phase == 3) begin
                sz = 5'd16;
            end else if ($urandom_range(0, 4) == 0) begin
                sz = SIZE_W'($urandom_range(0, 31));
            end else begin
                sz = SIZE_W'($urandom_range(1, 6));
            end
            set_matrix_size(sz);
            n = eff_size(sz);
            // every third phase runs with no idling on either side
            sender_gaps = (phase % 3 != 2);
            rx_stalls   = (phase % 3 != 2);
            for (i = 0; i < 15; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    send_compute(pick_row(n));
                end else if (pick < 42 && n < MAX_N) begin
                    send_compute(IDX_F_W'($urandom_range(n, MAX_N - 1)));
                end else if (pick < 47) begin
                    send_word(OP_UNUSED, IDX_F_W'($urandom), IDX_F_W'($urandom),
                              ELEM_W'($urandom));
                end else begin
                    op = ($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B;
                    if ($urandom_range(0, 4) != 0) begin
                        r = IDX_F_W'($urandom_range(0, n - 1));
                        c = IDX_F_W'($urandom_range(0, n - 1));
                    end else begin
                        r = IDX_F_W'($urandom);
                        c = IDX_F_W'($urandom);
                    end
                    send_word(op, r, c, rand_element());
                end
            end
        end
        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;
    endtask

    // Receiver: alternating ready/stall runs, always ready with stalls off, or a long hold-off on request
    initial begin
        bit run_high;
        int run_left;
        run_high = 1'b1;
        run_left = 0;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_if.ready <= 1'b1;
            end else if (!rx_stalls) begin
                out_if.ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_high = !run_high;
                    run_left = run_high ? $urandom_range(1, 10) : $urandom_range(1, 6);
                end
                out_if.ready <= run_high;
                run_left--;
            end
        end
    end

    // Product word checker, oldest expectation first
    always @(posedge i_clk) begin
        t_product want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_products.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected product word: row %0d col %0d value %0d last %0b",
                             out_if.out_row, out_if.out_col, out_if.product_value,
                             out_if.last);
                end
            end else begin
                want = expected_products.pop_front();
                if (out_if.out_row !== want.row || out_if.out_col !== want.col ||
                    out_if.product_value !== want.value || out_if.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("product mismatch: exp row %0d col %0d value %0d last %0b",
                                 want.row, want.col, want.value, want.last);
                        $display("                  got row %0d col %0d value %0d last %0b",
                                 out_if.out_row, out_if.out_col, out_if.product_value,
                                 out_if.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("matrix_multiply_engine verification failed");
            $finish;
        end
    end

    // Test sequence
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_if.valid   <= 1'b0;
        in_if.op      <= OP_LOAD_A;
        in_if.row     <= '0;
        in_if.col     <= '0;
        in_if.element <= '0;
        size_shadow    = SIZE_RESET;
        mismatch_count = 0;
        cycle_count    = 0;
        sender_gaps    = 1'b1;
        rx_stalls      = 1'b1;
        hold_req       = 1'b0;
        burst_left     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_stores();
        test_reset_size();
        test_size_extremes();
        test_output_holdoff();
        test_random_traffic();

        wait_drained();
        if (mismatch_count == 0 && expected_products.size() == 0) begin
            $display("matrix_multiply_engine verification clean");
        end else begin
            if (expected_products.size() != 0) begin
                $display("%0d product words never arrived", expected_products.size());
            end
            $display("matrix_multiply_engine verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
